/* rtl/core/wpr_pkg.sv */
// ----------------------------------------------------------------------------
// Probe request parser package
// Shared types and frame layout constants for the probe request parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wpr_pkg;

  // Frame layout
  localparam int HEADER_BYTES = 24;
  localparam int POS_W        = 16;
  localparam int SRC_FIRST    = 10;
  localparam int BSSID_FIRST  = 16;
  localparam int BSSID_END    = 22;

  // Frame control fields for a management probe request
  localparam logic [1:0] FC_TYPE_MGMT      = 2'h0;
  localparam logic [3:0] FC_SUBTYPE_PROBE  = 4'h4;

  // SSID element
  localparam logic [7:0] IE_ID_SSID  = 8'h00;
  localparam int         SSID_LEN_W  = 6;
  localparam int         SSID_SLOTS  = 32;
  localparam int         SSID_BITS   = SSID_SLOTS * 8;

  // Element walk phase
  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  // One frame byte moving from the input register into the parser
  typedef struct packed {
    logic       fire;
    logic       last;
    logic [7:0] data;
  } step_t;

  // Header capture result, valid on the last byte
  typedef struct packed {
    logic        accepted;
    logic [47:0] source;
    logic [47:0] bssid;
  } hdr_res_t;

  // SSID result, valid on the last byte
  typedef struct packed {
    logic [SSID_LEN_W-1:0] length;
    logic [SSID_BITS-1:0]  bytes;
  } ssid_res_t;

endpackage

`default_nettype wire

/* rtl/core/wpr_hdr_capture.sv */
// ----------------------------------------------------------------------------
// Probe request header capture
// Tracks the byte position, checks the frame control byte and collects the
// source address and BSSID.
// ----------------------------------------------------------------------------
`default_nettype none

module wpr_hdr_capture
  import wpr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire step_t    step,
  output logic          walk_en,
  output hdr_res_t      hdr
);

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic             type_ok;
  logic             type_ok_next;
  logic [47:0]      source_store;
  logic [47:0]      source_store_next;
  logic [47:0]      bssid_store;
  logic [47:0]      bssid_store_next;

  // Next values for the header fields.
  always_comb begin
    type_ok_next      = type_ok;
    source_store_next = source_store;
    bssid_store_next  = bssid_store;
    if (byte_position == '0) begin
      type_ok_next = (step.data[3:2] == FC_TYPE_MGMT) && (step.data[7:4] == FC_SUBTYPE_PROBE);
    end else if (byte_position >= POS_W'(SRC_FIRST) && byte_position < POS_W'(BSSID_FIRST)) begin
      source_store_next = {source_store[39:0], step.data};
    end else if (byte_position >= POS_W'(BSSID_FIRST) && byte_position < POS_W'(BSSID_END)) begin
      bssid_store_next = {bssid_store[39:0], step.data};
    end
    byte_position_next = (byte_position == '1) ? byte_position : byte_position + 1'b1;
  end

  // The element walk starts once the fixed header is through.
  assign walk_en = byte_position >= POS_W'(HEADER_BYTES);

  // Result seen on the last byte; a rejected frame reports all zero.
  always_comb begin
    hdr.accepted = type_ok_next && (byte_position_next >= POS_W'(HEADER_BYTES));
    hdr.source   = hdr.accepted ? source_store_next : '0;
    hdr.bssid    = hdr.accepted ? bssid_store_next : '0;
  end

  // State returns to reset after every last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      type_ok       <= 1'b0;
      source_store  <= '0;
      bssid_store   <= '0;
    end else if (step.fire) begin
      if (step.last) begin
        byte_position <= '0;
        type_ok       <= 1'b0;
        source_store  <= '0;
        bssid_store   <= '0;
      end else begin
        byte_position <= byte_position_next;
        type_ok       <= type_ok_next;
        source_store  <= source_store_next;
        bssid_store   <= bssid_store_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wpr_ie_walker.sv */
// ----------------------------------------------------------------------------
// Probe request element walker
// Walks the information elements after the header, keeps the body of the
// first SSID element and commits it when the whole element fits the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module wpr_ie_walker
  import wpr_pkg::*;
#(
  parameter int MAX_SSID_BYTES = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire step_t step,
  input  wire logic  walk_en,
  output ssid_res_t  ssid
);

  localparam int IDX_W = (MAX_SSID_BYTES > 1) ? $clog2(MAX_SSID_BYTES) : 1;

  phase_t                phase;
  phase_t                phase_next;
  logic                  is_ssid;
  logic                  is_ssid_next;
  logic [7:0]            remaining;
  logic [7:0]            remaining_next;
  logic [SSID_LEN_W-1:0] ssid_count;
  logic [SSID_LEN_W-1:0] ssid_count_next;
  logic                  committed;
  logic                  committed_next;
  logic                  buf_wr;
  logic [IDX_W-1:0]      buf_idx;
  logic [7:0]            ssid_buf [MAX_SSID_BYTES];

  assign buf_idx = ssid_count[IDX_W-1:0];

  // Phase register and walk state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_ID;
      is_ssid    <= 1'b0;
      remaining  <= '0;
      ssid_count <= '0;
      committed  <= 1'b0;
    end else if (step.fire) begin
      if (step.last) begin
        phase      <= PH_ID;
        is_ssid    <= 1'b0;
        remaining  <= '0;
        ssid_count <= '0;
        committed  <= 1'b0;
      end else begin
        phase      <= phase_next;
        is_ssid    <= is_ssid_next;
        remaining  <= remaining_next;
        ssid_count <= ssid_count_next;
        committed  <= committed_next;
      end
    end
  end

  // SSID byte store; slots past the count are masked on the way out.
  always_ff @(posedge clk) begin
    if (step.fire && buf_wr) begin
      ssid_buf[buf_idx] <= step.data;
    end
  end

  // Next phase and element bookkeeping.
  always_comb begin
    phase_next      = phase;
    is_ssid_next    = is_ssid;
    remaining_next  = remaining;
    ssid_count_next = ssid_count;
    committed_next  = committed;
    buf_wr          = 1'b0;
    if (walk_en) begin
      case (phase)
        PH_ID: begin
          is_ssid_next = (step.data == IE_ID_SSID);
          phase_next   = PH_LEN;
        end
        PH_LEN: begin
          remaining_next = step.data;
          if (step.data == 8'h00) begin
            if (is_ssid) begin
              committed_next = 1'b1;
              phase_next     = PH_DONE;
            end else begin
              phase_next = PH_ID;
            end
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          if (is_ssid && ssid_count < SSID_LEN_W'(MAX_SSID_BYTES)) begin
            buf_wr          = 1'b1;
            ssid_count_next = ssid_count + 1'b1;
          end
          remaining_next = remaining - 1'b1;
          if (remaining_next == 8'h00) begin
            if (is_ssid) begin
              committed_next = 1'b1;
              phase_next     = PH_DONE;
            end else begin
              phase_next = PH_ID;
            end
          end
        end
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        default: begin
          phase_next = PH_ID;
        end
      endcase
    end
  end

  // Committed length and the kept bytes, including a byte written this cycle.
  assign ssid.length = committed_next ? ssid_count_next : '0;

  for (genvar i = 0; i < SSID_SLOTS; i++) begin : g_slot
    if (i < MAX_SSID_BYTES) begin : g_kept
      logic [7:0] slot;
      assign slot = (buf_wr && buf_idx == IDX_W'(i)) ? step.data : ssid_buf[i];
      assign ssid.bytes[i*8 +: 8] = (SSID_LEN_W'(i) < ssid.length) ? slot : 8'h00;
    end else begin : g_unused
      assign ssid.bytes[i*8 +: 8] = 8'h00;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wpr_out_reg.sv */
// ----------------------------------------------------------------------------
// Probe request result register
// Holds one parsed frame result until the output transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module wpr_out_reg
  import wpr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire hdr_res_t          hdr,
  input  wire ssid_res_t         ssid,
  input  wire logic signed [7:0] meta_dbm,
  input  wire logic [7:0]        meta_channel,
  input  wire logic [31:0]       meta_time,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic                   accepted,
  output logic [47:0]            source_mac,
  output logic [47:0]            bssid_mac,
  output logic [5:0]             ssid_length,
  output logic [63:0]            ssid_word0,
  output logic [63:0]            ssid_word1,
  output logic [63:0]            ssid_word2,
  output logic [63:0]            ssid_word3,
  output logic signed [7:0]      out_signal_dbm,
  output logic [7:0]             out_channel,
  output logic [31:0]            out_time_us
);

  // Valid flag: set on load, cleared once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; a rejected frame carries zeros throughout.
  always_ff @(posedge clk) begin
    if (load) begin
      accepted       <= hdr.accepted;
      source_mac     <= hdr.source;
      bssid_mac      <= hdr.bssid;
      ssid_length    <= hdr.accepted ? ssid.length : '0;
      ssid_word0     <= hdr.accepted ? ssid.bytes[63:0] : '0;
      ssid_word1     <= hdr.accepted ? ssid.bytes[127:64] : '0;
      ssid_word2     <= hdr.accepted ? ssid.bytes[191:128] : '0;
      ssid_word3     <= hdr.accepted ? ssid.bytes[255:192] : '0;
      out_signal_dbm <= hdr.accepted ? meta_dbm : 8'sd0;
      out_channel    <= hdr.accepted ? meta_channel : '0;
      out_time_us    <= hdr.accepted ? meta_time : '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wifi_probe_request_parser.sv */
// ----------------------------------------------------------------------------
// Result path: input register, parse stage, output register.
// One frame byte per cycle unless the output stalls, set by the single parse stage.
// A stalled output holds the parse stage and then the input register.
// Reset clears the valid flags and all frame state; payload is not reset.
// ----------------------------------------------------------------------------
// 802.11 probe request parser
// Takes a frame one byte at a time and gives the source address, BSSID and
// SSID of a probe request, one result per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module wifi_probe_request_parser
  import wpr_pkg::*;
#(
  parameter int MAX_SSID_BYTES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic signed [7:0] signal_dbm,
  input  wire logic [7:0]        radio_channel,
  input  wire logic [31:0]       time_us,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   accepted,
  output logic [47:0]            source_mac,
  output logic [47:0]            bssid_mac,
  output logic [5:0]             ssid_length,
  output logic [63:0]            ssid_word0,
  output logic [63:0]            ssid_word1,
  output logic [63:0]            ssid_word2,
  output logic [63:0]            ssid_word3,
  output logic signed [7:0]      out_signal_dbm,
  output logic [7:0]             out_channel,
  output logic [31:0]            out_time_us
);

  logic              in_full;
  logic [7:0]        in_data;
  logic              in_last;
  logic signed [7:0] in_dbm;
  logic [7:0]        in_channel;
  logic [31:0]       in_time;
  logic              blocked;
  logic              take;
  step_t             step;
  logic              walk_en;
  hdr_res_t          hdr;
  ssid_res_t         ssid;

  // The parse stage moves whenever the result register can take a result.
  assign blocked  = out_valid && out_stall;
  assign in_stall = in_full && blocked;
  assign take     = in_valid && !in_stall;

  assign step.fire = in_full && !blocked;
  assign step.last = in_last;
  assign step.data = in_data;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (step.fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_data    <= data_byte;
      in_last    <= last_byte;
      in_dbm     <= signal_dbm;
      in_channel <= radio_channel;
      in_time    <= time_us;
    end
  end

  wpr_hdr_capture u_hdr (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .walk_en (walk_en),
    .hdr     (hdr)
  );

  wpr_ie_walker #(
    .MAX_SSID_BYTES (MAX_SSID_BYTES)
  ) u_walker (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .walk_en (walk_en),
    .ssid    (ssid)
  );

  wpr_out_reg u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (step.fire && step.last),
    .hdr            (hdr),
    .ssid           (ssid),
    .meta_dbm       (in_dbm),
    .meta_channel   (in_channel),
    .meta_time      (in_time),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .accepted       (accepted),
    .source_mac     (source_mac),
    .bssid_mac      (bssid_mac),
    .ssid_length    (ssid_length),
    .ssid_word0     (ssid_word0),
    .ssid_word1     (ssid_word1),
    .ssid_word2     (ssid_word2),
    .ssid_word3     (ssid_word3),
    .out_signal_dbm (out_signal_dbm),
    .out_channel    (out_channel),
    .out_time_us    (out_time_us)
  );

endmodule

`default_nettype wire
